>>> src/gwng_pkg.sv
// Shared types, constants and helpers for the grid neighbour generator.
`default_nettype none

package gwng_pkg;

    localparam int MAX_DIM  = 64;
    // Largest usable grid side: coordinates are six bits wide.
    localparam int COORD_W  = 6;
    localparam int MAP_SIDE = 1 << COORD_W;
    localparam int DIM_LIM  = (MAX_DIM < MAP_SIDE) ? MAX_DIM : MAP_SIDE;
    localparam int DIM_W    = COORD_W + 1;
    localparam int CFG_W    = 7;
    localparam int COST_W   = 15;
    localparam int NUM_DIR  = 8;
    localparam int DIR_W    = $clog2(NUM_DIR);

    localparam logic [COST_W-1:0] COST_ORTHO = 15'd16384;
    localparam logic [COST_W-1:0] COST_DIAG  = 15'd23170;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_EIGHT  = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [MAP_SIDE-1:0] row_t;

    typedef struct packed {
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
        logic             eight;
    } cfg_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic [COORD_W-1:0] addr;
        row_t               wdata;
    } ram_req_t;

    // Column offset of a direction: +x, -x, +y, -y, then the four diagonals.
    function automatic logic [COORD_W-1:0] dir_x(input logic [COORD_W-1:0] cx,
                                                 input logic [DIR_W-1:0] dir);
        logic [COORD_W-1:0] r;
        case (dir)
            3'd0, 3'd4, 3'd5: r = cx + COORD_W'(1);
            3'd1, 3'd6, 3'd7: r = cx - COORD_W'(1);
            default:          r = cx;
        endcase
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] dir_y(input logic [COORD_W-1:0] cy,
                                                 input logic [DIR_W-1:0] dir);
        logic [COORD_W-1:0] r;
        case (dir)
            3'd2, 3'd4, 3'd6: r = cy + COORD_W'(1);
            3'd3, 3'd5, 3'd7: r = cy - COORD_W'(1);
            default:          r = cy;
        endcase
        return r;
    endfunction

    function automatic logic [DIR_W-1:0] lowest_dir(input logic [NUM_DIR-1:0] m);
        logic [DIR_W-1:0] r;
        r = '0;
        for (int i = NUM_DIR - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = DIR_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/grid_walkable_neighbor_generator_core.sv
// Top level: configuration registers, blocked-cell bitmap and request sequencer.
//
//   Channel  Signals                                            Direction
//   in       in_valid/in_ready, op, cell_x, cell_y,
//            blocked_value                                      request in
//   out      out_valid/out_ready, neighbor_x, neighbor_y,
//            step_cost, is_diagonal, found, last                result out
//   cfg      cfg_wr_en, cfg_index, cfg_data                     register write
//
// A write request steps through accept, row read and row write-back.
// A query gives n results (n = 1..8): three row reads through the single bitmap
// port, an evaluate step, then one result per cycle while the output is not stalled.
// Reset clears all row valid bits at once, so every cell reads walkable; no sweep.
// A stalled output holds the sequencer in emission; a new request is taken once the
// last result of the previous one sits in the output register.
`default_nettype none

module grid_walkable_neighbor_generator_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [gwng_pkg::COORD_W-1:0]  cell_x,
    input  wire logic [gwng_pkg::COORD_W-1:0]  cell_y,
    input  wire logic                          blocked_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gwng_pkg::COORD_W-1:0]       neighbor_x,
    output logic [gwng_pkg::COORD_W-1:0]       neighbor_y,
    output logic [gwng_pkg::COST_W-1:0]        step_cost,
    output logic                               is_diagonal,
    output logic                               found,
    output logic                               last,
    input  wire logic                          cfg_wr_en,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [gwng_pkg::CFG_W-1:0]    cfg_data
);
    import gwng_pkg::*;

    logic [DIM_W-1:0] width_reg, height_reg;
    logic             eight_reg;
    cfg_t             cfg;
    ram_req_t         ram_req;
    row_t             ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(64);
            height_reg <= DIM_W'(64);
            eight_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                CFG_EIGHT:  eight_reg  <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Clamp oversized dimensions to the largest grid the map holds.
    always_comb
    begin
        cfg.eff_w = (width_reg > DIM_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : width_reg;
        cfg.eff_h = (height_reg > DIM_W'(DIM_LIM)) ? DIM_W'(DIM_LIM) : height_reg;
        cfg.eight = eight_reg;
    end

    gwng_row_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    gwng_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .blocked_value (blocked_value),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .neighbor_x    (neighbor_x),
        .neighbor_y    (neighbor_y),
        .step_cost     (step_cost),
        .is_diagonal   (is_diagonal),
        .found         (found),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> src/gwng_row_ram.sv
// Blocked-cell bitmap: one row per entry, per-row valid bits give the cleared reset.
`default_nettype none

module gwng_row_ram (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gwng_pkg::ram_req_t req,
    output logic [gwng_pkg::MAP_SIDE-1:0] rdata
);
    import gwng_pkg::*;

    row_t                mem [MAP_SIDE];
    row_t                rdata_reg;
    logic [MAP_SIDE-1:0] valid_reg;
    logic                rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    // A row never written reads as all walkable.
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

>>> src/gwng_nbr_eval.sv
// Walkability mask of the eight neighbours from three bitmap rows.
`default_nettype none

module gwng_nbr_eval (
    input  wire logic [gwng_pkg::COORD_W-1:0]  cx,
    input  wire logic [gwng_pkg::COORD_W-1:0]  cy,
    input  wire gwng_pkg::cfg_t                cfg,
    input  wire logic [gwng_pkg::MAP_SIDE-1:0] row_up,
    input  wire logic [gwng_pkg::MAP_SIDE-1:0] row_mid,
    input  wire logic [gwng_pkg::MAP_SIDE-1:0] row_dn,
    output logic [gwng_pkg::NUM_DIR-1:0]       mask
);
    import gwng_pkg::*;

    logic [DIM_W-1:0]   xp, x0, xm, yp, y0, ym;
    logic               col_p, col_0, col_m, rw_p, rw_0, rw_m;
    logic [COORD_W-1:0] ip, im;
    logic               w_px, w_mx, w_py, w_my;
    logic               w_pp, w_pm, w_mp, w_mm;

    always_comb
    begin
        // Minus one wraps to all ones, which is never in bounds.
        x0 = {1'b0, cx};
        xp = x0 + DIM_W'(1);
        xm = x0 - DIM_W'(1);
        y0 = {1'b0, cy};
        yp = y0 + DIM_W'(1);
        ym = y0 - DIM_W'(1);

        col_p = xp < cfg.eff_w;
        col_0 = x0 < cfg.eff_w;
        col_m = xm < cfg.eff_w;
        rw_p  = yp < cfg.eff_h;
        rw_0  = y0 < cfg.eff_h;
        rw_m  = ym < cfg.eff_h;

        ip = xp[COORD_W-1:0];
        im = xm[COORD_W-1:0];

        w_px = col_p & rw_0 & ~row_mid[ip];
        w_mx = col_m & rw_0 & ~row_mid[im];
        w_py = col_0 & rw_p & ~row_dn[cx];
        w_my = col_0 & rw_m & ~row_up[cx];
        w_pp = col_p & rw_p & ~row_dn[ip];
        w_pm = col_p & rw_m & ~row_up[ip];
        w_mp = col_m & rw_p & ~row_dn[im];
        w_mm = col_m & rw_m & ~row_up[im];

        mask[0] = w_px;
        mask[1] = w_mx;
        mask[2] = w_py;
        mask[3] = w_my;
        // Drop a diagonal that would cut a blocked corner.
        mask[4] = cfg.eight & w_pp & w_px & w_py;
        mask[5] = cfg.eight & w_pm & w_px & w_my;
        mask[6] = cfg.eight & w_mp & w_mx & w_py;
        mask[7] = cfg.eight & w_mm & w_mx & w_my;
    end

endmodule

`default_nettype wire

>>> src/gwng_seq.sv
// Request sequencer: row reads, read-modify-write of the bitmap and result emission.
`default_nettype none

module gwng_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gwng_pkg::cfg_t                cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [gwng_pkg::COORD_W-1:0]  cell_x,
    input  wire logic [gwng_pkg::COORD_W-1:0]  cell_y,
    input  wire logic                          blocked_value,
    output gwng_pkg::ram_req_t                 ram_req,
    input  wire logic [gwng_pkg::MAP_SIDE-1:0] ram_rdata,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gwng_pkg::COORD_W-1:0]       neighbor_x,
    output logic [gwng_pkg::COORD_W-1:0]       neighbor_y,
    output logic [gwng_pkg::COST_W-1:0]        step_cost,
    output logic                               is_diagonal,
    output logic                               found,
    output logic                               last
);
    import gwng_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_MID,
        ST_RD_DN,
        ST_RD_UP,
        ST_EVAL,
        ST_EMIT,
        ST_WR_BACK
    } state_t;

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    logic                 bval_reg, bval_next;
    logic [COORD_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    row_t                 row_mid_reg, row_mid_next, row_dn_reg, row_dn_next;
    logic [NUM_DIR-1:0]   mask_reg, mask_next, mask_eval, mask_rest;
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   nx_reg, nx_next, ny_reg, ny_next;
    logic [COST_W-1:0]    cost_reg, cost_next;
    logic                 diag_reg, diag_next, found_reg, found_next, last_reg, last_next;
    logic [DIR_W-1:0]     dir;
    logic                 out_load, wr_in_bounds;
    row_t                 wr_row;

    gwng_nbr_eval u_eval (
        .cx      (cx_reg),
        .cy      (cy_reg),
        .cfg     (cfg),
        .row_up  (ram_rdata),
        .row_mid (row_mid_reg),
        .row_dn  (row_dn_reg),
        .mask    (mask_eval)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        bval_next      = bval_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        row_mid_next   = row_mid_reg;
        row_dn_next    = row_dn_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !out_ready;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        cost_next      = cost_reg;
        diag_next      = diag_reg;
        found_next     = found_reg;
        last_next      = last_reg;

        ram_req        = '0;
        dir            = lowest_dir(mask_reg);
        mask_rest      = mask_reg & (mask_reg - NUM_DIR'(1));
        wr_in_bounds   = ({1'b0, cx_reg} < cfg.eff_w) && ({1'b0, cy_reg} < cfg.eff_h);
        wr_row         = ram_rdata;
        wr_row[cx_reg] = bval_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    bval_next  = blocked_value;
                    cx_next    = cell_x;
                    cy_next    = cell_y;
                    state_next = ST_RD_MID;
                end
            end
            ST_RD_MID:
            begin
                ram_req.rd_en = 1'b1;
                ram_req.addr  = cy_reg;
                state_next    = (op_reg == OP_WRITE) ? ST_WR_BACK : ST_RD_DN;
            end
            ST_RD_DN:
            begin
                row_mid_next  = ram_rdata;
                ram_req.rd_en = 1'b1;
                ram_req.addr  = cy_reg + COORD_W'(1);
                state_next    = ST_RD_UP;
            end
            ST_RD_UP:
            begin
                row_dn_next   = ram_rdata;
                ram_req.rd_en = 1'b1;
                ram_req.addr  = cy_reg - COORD_W'(1);
                state_next    = ST_EVAL;
            end
            ST_EVAL:
            begin
                mask_next  = mask_eval;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (mask_reg == '0)
                    begin
                        // Empty marker: no neighbour qualified.
                        nx_next    = '0;
                        ny_next    = '0;
                        cost_next  = '0;
                        diag_next  = 1'b0;
                        found_next = 1'b0;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        nx_next    = dir_x(cx_reg, dir);
                        ny_next    = dir_y(cy_reg, dir);
                        diag_next  = dir[DIR_W-1];
                        cost_next  = dir[DIR_W-1] ? COST_DIAG : COST_ORTHO;
                        found_next = 1'b1;
                        last_next  = (mask_rest == '0);
                        mask_next  = mask_rest;
                        if (mask_rest == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_WR_BACK:
            begin
                // Drop writes that fall outside the grid in use.
                ram_req.wr_en = wr_in_bounds;
                ram_req.addr  = cy_reg;
                ram_req.wdata = wr_row;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_WRITE;
            bval_reg      <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            row_mid_reg   <= '0;
            row_dn_reg    <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            nx_reg        <= '0;
            ny_reg        <= '0;
            cost_reg      <= '0;
            diag_reg      <= 1'b0;
            found_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            bval_reg      <= bval_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            row_mid_reg   <= row_mid_next;
            row_dn_reg    <= row_dn_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            nx_reg        <= nx_next;
            ny_reg        <= ny_next;
            cost_reg      <= cost_next;
            diag_reg      <= diag_next;
            found_reg     <= found_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign neighbor_x  = nx_reg;
    assign neighbor_y  = ny_reg;
    assign step_cost   = cost_reg;
    assign is_diagonal = diag_reg;
    assign found       = found_reg;
    assign last        = last_reg;

    a_no_rd_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.rd_en && ram_req.wr_en))
        else $error("bitmap read and write in the same cycle");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> last_reg)
        else $error("empty marker not flagged as last");

    a_last_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last result");

    a_diag_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |->
            (step_cost == (diag_reg ? COST_DIAG : COST_ORTHO)))
        else $error("step cost does not match direction");

endmodule

`default_nettype wire
